// File: hw/rtl/u8u16_pkg.sv
`timescale 1ns / 1ps

package u8u16_pkg;

   localparam logic [15:0] UNIT_TILDE   = 16'h007E;
   localparam logic [31:0] BMP_LIMIT    = 32'h0000_FFFF;
   localparam logic [31:0] PLANE_LIMIT  = 32'h0010_FFFF;
   localparam logic [20:0] PLANE_BASE   = 21'h1_0000;
   localparam logic [5:0]  HIGH_PREFIX  = 6'b110110;  // 0xD800 >> 10
   localparam logic [5:0]  LOW_PREFIX   = 6'b110111;  // 0xDC00 >> 10

   // Number of trailing bytes announced by a lead byte.
   function automatic logic [2:0] trailing_count(input logic [7:0] lead);
      logic [2:0] cnt;
      cnt = 3'd5;
      if (lead < 8'hC0)      cnt = 3'd0;
      else if (lead < 8'hE0) cnt = 3'd1;
      else if (lead < 8'hF0) cnt = 3'd2;
      else if (lead < 8'hF8) cnt = 3'd3;
      else if (lead < 8'hFC) cnt = 3'd4;
      return cnt;
   endfunction

   // Offset removed from the folded bytes for a sequence of this length.
   function automatic logic [31:0] seq_offset(input logic [2:0] len);
      logic [31:0] ofs;
      case (len)
         3'd1:    ofs = 32'h0000_3080;
         3'd2:    ofs = 32'h000E_2080;
         3'd3:    ofs = 32'h03C8_2080;
         3'd4:    ofs = 32'hFA08_2080;
         3'd5:    ofs = 32'h8208_2080;
         default: ofs = 32'h0000_0000;
      endcase
      return ofs;
   endfunction

endpackage

// File: hw/rtl/utf8_to_utf16_transcoder.sv
`timescale 1ns / 1ps

// UTF-8 to UTF-16 transcoder.
// Input channel (req_): one UTF-8 byte per item in req_tdata, req_tlast set on
// the final byte of a text. Bytes are folded in with no validation.
// Result channel (rsp_): one UTF-16 code unit per item in rsp_tdata. rsp_tlast
// marks the last unit caused by one input byte; rsp_tuser marks units that
// belong to the text's final byte. A code point above 0xFFFF leaves as a
// surrogate pair (high half first), one above 0x10FFFF and a text that ends
// inside a sequence leave as a single '~'.
// A unit is offered on rsp_ once the byte completing its sequence has passed
// the fold register and the result register. Throughput: one byte per cycle
// while req_tready is high; a surrogate pair holds the result register until
// both halves leave; the next completed sequence waits in the fold register.
// Structure: a fold register (sequence state plus the folded value) feeds a
// result register of up to two units; the offset subtract and the split into
// halves sit between them.
// Reset clears the sequence state and empties both registers.
// When the receiver stalls, the result register holds its unit, the fold
// register fills, and req_tready falls until the result register frees up.
module utf8_to_utf16_transcoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // text_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [15:0] code_unit
   output logic        rsp_tlast,   // run_last
   output logic        rsp_tuser    // [0] text_done
);
   import u8u16_pkg::*;

   // Sequence state
   logic [31:0] acc_ff, acc_in;
   logic [2:0]  rem_ff, rem_in;
   logic [2:0]  len_ff, len_in;

   // Fold register: one item that produces output
   logic        pnt_valid_ff, pnt_valid_in;
   logic [31:0] pnt_acc_ff;
   logic [2:0]  pnt_len_ff;
   logic        pnt_tilde_ff;
   logic        pnt_done_ff;

   // Result register: up to two units
   logic [1:0]  out_cnt_ff, out_cnt_in;
   logic [15:0] out_hi_ff, out_hi_in;
   logic [15:0] out_lo_ff, out_lo_in;
   logic        out_done_ff, out_done_in;

   logic        req_fire, rsp_fire, out_load, pnt_adv;
   logic [31:0] fold_acc;
   logic [2:0]  fold_rem, fold_len;
   logic        fold_emit;
   logic [31:0] code_pt;
   logic [19:0] sup_ofs;
   logic [20:0] sup_diff;

   assign req_fire = req_tvalid & req_tready;
   assign rsp_fire = rsp_tvalid & rsp_tready;
   assign out_load = (out_cnt_ff == 2'd0) | ((out_cnt_ff == 2'd1) & rsp_fire);
   assign pnt_adv  = pnt_valid_ff & out_load;
   assign req_tready = ~pnt_valid_ff | pnt_adv;

   // Fold the byte into the sequence
   always_comb begin
      if (rem_ff == 3'd0) begin
         fold_acc = {24'd0, req_tdata};
         fold_len = trailing_count(req_tdata);
         fold_rem = fold_len;
      end else begin
         fold_acc = {acc_ff[25:0], 6'd0} + {24'd0, req_tdata};
         fold_len = len_ff;
         fold_rem = rem_ff - 3'd1;
      end
      fold_emit = (fold_rem == 3'd0);
   end

   always_comb begin
      acc_in = acc_ff;
      rem_in = rem_ff;
      len_in = len_ff;
      pnt_valid_in = pnt_valid_ff & ~pnt_adv;
      if (req_fire) begin
         acc_in = fold_acc;
         rem_in = fold_rem;
         len_in = fold_len;
         if (fold_emit) begin
            acc_in = 32'd0;
            len_in = 3'd0;
         end
         // drop any partial sequence at the end of the text
         if (req_tlast) begin
            acc_in = 32'd0;
            rem_in = 3'd0;
            len_in = 3'd0;
         end
         pnt_valid_in = fold_emit | req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 32'd0;
         rem_ff       <= 3'd0;
         len_ff       <= 3'd0;
         pnt_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rem_ff       <= rem_in;
         len_ff       <= len_in;
         pnt_valid_ff <= pnt_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         pnt_acc_ff   <= fold_acc;
         pnt_len_ff   <= fold_len;
         pnt_tilde_ff <= ~fold_emit;
         pnt_done_ff  <= req_tlast;
      end
   end

   // Remove the length offset and split into units
   assign code_pt  = pnt_acc_ff - seq_offset(pnt_len_ff);
   assign sup_diff = code_pt[20:0] - PLANE_BASE;
   assign sup_ofs  = sup_diff[19:0];

   always_comb begin
      out_cnt_in  = out_cnt_ff;
      out_hi_in   = out_hi_ff;
      out_lo_in   = out_lo_ff;
      out_done_in = out_done_ff;
      if (rsp_fire) begin
         // advance the low half up after the high half leaves
         out_cnt_in = out_cnt_ff - 2'd1;
         out_hi_in  = out_lo_ff;
      end
      if (pnt_adv) begin
         out_done_in = pnt_done_ff;
         out_cnt_in  = 2'd1;
         out_lo_in   = out_lo_ff;
         if (pnt_tilde_ff || code_pt > PLANE_LIMIT) begin
            out_hi_in = UNIT_TILDE;
         end else if (code_pt <= BMP_LIMIT) begin
            out_hi_in = code_pt[15:0];
         end else begin
            out_hi_in  = {HIGH_PREFIX, sup_ofs[19:10]};
            out_lo_in  = {LOW_PREFIX, sup_ofs[9:0]};
            out_cnt_in = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_cnt_ff <= 2'd0;
      end else begin
         out_cnt_ff <= out_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_hi_ff   <= out_hi_in;
      out_lo_ff   <= out_lo_in;
      out_done_ff <= out_done_in;
   end

   assign rsp_tvalid = (out_cnt_ff != 2'd0);
   assign rsp_tdata  = out_hi_ff;
   assign rsp_tlast  = (out_cnt_ff == 2'd1);
   assign rsp_tuser  = out_done_ff;

endmodule

// File: hw/rtl/u8u16_checker.sv
`timescale 1ns / 1ps

module u8u16_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [15:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic        rsp_tuser
);
   import u8u16_pkg::*;

   // Hold a stalled unit.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled unit changed");

   // Empty result register after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("unit offered right after reset");

   // A unit that is not the last of its byte is a high surrogate.
   a_high_half: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[15:10] == HIGH_PREFIX)
      else $error("first of a pair is not a high surrogate");

   // The low half follows at once, from the same text position.
   a_low_half: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && !rsp_tlast |=> rsp_tvalid && rsp_tlast
         && rsp_tdata[15:10] == LOW_PREFIX && rsp_tuser == $past(rsp_tuser))
      else $error("low surrogate missing after high half");

endmodule

bind utf8_to_utf16_transcoder u8u16_checker u_u8u16_checker (.*);
